@@ hw/rtl/etc_pkg.sv @@
// Shared types, constants and the month table for the epoch to calendar pipeline.
package etc_pkg;

    // Port field widths
    localparam int EPOCH_W   = 32;
    localparam int YEAR_W    = 12;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int WDAY_W    = 3;
    localparam int CFG_IDX_W = 8;

    // Internal widths
    localparam int DAYS_W  = 16;   // whole days, at most 49710
    localparam int TOD_W   = 17;   // seconds of day
    localparam int DOE_W   = 18;   // day of era
    localparam int YOE_W   = 9;    // year of era
    localparam int DOY_W   = 9;    // day of March-based year
    localparam int MP_W    = 4;    // March-based month
    localparam int Q1460_W = 7;    // leap cycles within the era
    localparam int N_W     = 11;   // 5 * doy + 2
    localparam int WD_W    = 17;   // days + 4
    localparam int WQ_W    = 13;   // (days + 4) / 7
    localparam int MREM_W  = 12;   // seconds of hour

    // Register reset values
    localparam logic [EPOCH_W-1:0] RESET_FLOOR = 32'd1600000000;
    localparam logic [EPOCH_W-1:0] RESET_MAX   = 32'd4102444799;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FLOOR = CFG_IDX_W'(0),
        CFG_MAX_EPOCH  = CFG_IDX_W'(1)
    } t_cfg_idx;

    // 86400 = 675 << 7
    localparam int SEC_SHIFT     = 7;
    localparam int DAY_DIV       = 675;
    localparam int DAY_K         = EPOCH_W - SEC_SHIFT;
    localparam int DAY_RECIP     = (1 << DAY_K) / DAY_DIV;

    localparam int SECS_PER_HOUR = 3600;
    localparam int HOUR_RECIP    = (1 << TOD_W) / SECS_PER_HOUR;
    localparam int SECS_PER_MIN  = 60;
    localparam int MIN_RECIP     = (1 << MREM_W) / SECS_PER_MIN;
    localparam int WEEK_DAYS     = 7;
    localparam int WEEK_RECIP    = (1 << WD_W) / WEEK_DAYS;
    localparam int WEEK_OFFSET   = 4;    // day 0 was a Thursday

    // Era split: only eras 4 and 5 are reachable from a 32-bit epoch
    localparam int DAYS_TO_MARCH_ERA = 719468;
    localparam int DAYS_PER_ERA      = 146097;
    localparam int ERA_FIRST         = 4;
    localparam int ERA_SPLIT    = (ERA_FIRST + 1) * DAYS_PER_ERA - DAYS_TO_MARCH_ERA;
    localparam int DOE_OFF_LO   = DAYS_TO_MARCH_ERA - ERA_FIRST * DAYS_PER_ERA;
    localparam int YEAR_BASE_LO = ERA_FIRST * 400;
    localparam int YEAR_BASE_HI = (ERA_FIRST + 1) * 400;

    localparam int LEAP_DAYS    = 1460;
    localparam int LEAP_RECIP   = (1 << DOE_W) / LEAP_DAYS;
    localparam int CENT_DAYS    = 36524;
    localparam int ERA_LAST_DAY = 146096;
    localparam int YEAR_DAYS    = 365;
    localparam int YEAR_RECIP   = (1 << DOE_W) / YEAR_DAYS;
    localparam int MONTH_SPAN   = 153;
    localparam int MP_RECIP     = (1 << N_W) / MONTH_SPAN;

    // Pipeline depths
    localparam int SPLIT_LAT = 3;
    localparam int DATE_LAT  = 9;
    localparam int CLK_LAT   = 4;
    localparam int PAD_DEPTH = DATE_LAT - CLK_LAT;
    localparam int TOTAL_LAT = SPLIT_LAT + DATE_LAT;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [WDAY_W-1:0]   weekday;
        logic                in_range;
    } t_clock;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    // First day of each March-based month: (153 * mp + 2) / 5
    function automatic logic [DOY_W-1:0] month_offset(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/epoch_to_calendar.sv @@
// Top level: Unix epoch seconds to Gregorian date, time of day and weekday.
//
//  channel  | signals                                   | flow
//  ---------+-------------------------------------------+---------------------------------
//  request  | start, busy, i_epoch_seconds              | taken when start && !busy
//  result   | o_strobe, o_year .. o_in_range            | one-cycle strobe, no back-pressure
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_index,    | written when valid && ready;
//           | i_cfg_data                                | 0 sync_floor, 1 max_epoch
//
// One request per cycle; busy never rises. Each request passes through 3 stages
// that split seconds into days and seconds of day (reciprocal multiply by 1/675
// and a one-step correction), then 9 stages of date arithmetic that set the depth;
// the time-of-day path is padded to match. Synchronous reset clears the valid
// pipeline and restores the bound registers. The receiver cannot stall, so the
// pipeline never holds.
module epoch_to_calendar (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [etc_pkg::EPOCH_W-1:0]     i_epoch_seconds,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [etc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [etc_pkg::EPOCH_W-1:0]     i_cfg_data,
    output logic                            o_strobe,
    output logic [etc_pkg::YEAR_W-1:0]      o_year,
    output logic [etc_pkg::MONTH_W-1:0]     o_month,
    output logic [etc_pkg::DAY_W-1:0]       o_day,
    output logic [etc_pkg::HOUR_W-1:0]      o_hour,
    output logic [etc_pkg::MINUTE_W-1:0]    o_minute,
    output logic [etc_pkg::SECOND_W-1:0]    o_second,
    output logic [etc_pkg::WDAY_W-1:0]      o_weekday,
    output logic                            o_in_range
);

    localparam int XW     = etc_pkg::EPOCH_W - etc_pkg::SEC_SHIFT;   // epoch / 128
    localparam int PROD_W = XW + etc_pkg::DAYS_W;
    localparam int RR_W   = etc_pkg::TOD_W - etc_pkg::SEC_SHIFT;     // remainder / 128

    // Bound registers
    logic [etc_pkg::EPOCH_W-1:0] r_sync_floor;
    logic [etc_pkg::EPOCH_W-1:0] r_max_epoch;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_floor <= etc_pkg::RESET_FLOOR;
            r_max_epoch  <= etc_pkg::RESET_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                etc_pkg::CFG_SYNC_FLOOR: r_sync_floor <= i_cfg_data;
                etc_pkg::CFG_MAX_EPOCH:  r_max_epoch  <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // Stage A: capture request, range check against current bounds
    logic                           n_accept;
    logic                           n_ok;
    logic                           r_a_vld;
    logic [etc_pkg::EPOCH_W-1:0]    r_a_ep;
    logic                           r_a_ok;

    assign n_accept = start && !busy;
    assign n_ok     = (i_epoch_seconds >= r_sync_floor) && (i_epoch_seconds <= r_max_epoch);

    // Stage B: day estimate, (epoch >> 7) * floor(2^25 / 675) >> 25, low by at most one
    logic [PROD_W-1:0]              n_b_prod;
    logic                           r_b_vld;
    logic [etc_pkg::EPOCH_W-1:0]    r_b_ep;
    logic                           r_b_ok;
    logic [etc_pkg::DAYS_W-1:0]     r_b_q0;

    assign n_b_prod = PROD_W'(r_a_ep[etc_pkg::EPOCH_W-1:etc_pkg::SEC_SHIFT])
                    * PROD_W'(etc_pkg::DAY_RECIP);

    // Stage C: correct the day count, rebuild seconds of day
    logic [XW-1:0]                  n_c_rem;
    logic                           n_c_fix;
    logic [XW-1:0]                  n_c_rr;
    logic                           r_c_vld;
    logic                           r_c_ok;
    logic [etc_pkg::DAYS_W-1:0]     r_c_days;
    logic [etc_pkg::TOD_W-1:0]      r_c_tod;

    assign n_c_rem = r_b_ep[etc_pkg::EPOCH_W-1:etc_pkg::SEC_SHIFT]
                   - XW'(r_b_q0) * XW'(etc_pkg::DAY_DIV);
    assign n_c_fix = n_c_rem >= XW'(etc_pkg::DAY_DIV);
    assign n_c_rr  = n_c_fix ? n_c_rem - XW'(etc_pkg::DAY_DIV) : n_c_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= n_accept;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_a_ep <= i_epoch_seconds;
            r_a_ok <= n_ok;
        end
        r_b_ep   <= r_a_ep;
        r_b_ok   <= r_a_ok;
        r_b_q0   <= n_b_prod[PROD_W-1 -: etc_pkg::DAYS_W];
        r_c_ok   <= r_b_ok;
        r_c_days <= r_b_q0 + etc_pkg::DAYS_W'(n_c_fix);
        r_c_tod  <= {n_c_rr[RR_W-1:0], r_b_ep[etc_pkg::SEC_SHIFT-1:0]};
    end

    // Date and time-of-day paths run side by side from stage C
    logic               w_date_vld;
    etc_pkg::t_date     w_date;
    etc_pkg::t_clock    w_clock;

    etc_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_c_vld),
        .i_days  (r_c_days),
        .o_vld   (w_date_vld),
        .o_date  (w_date)
    );

    etc_clock u_clock (
        .i_clk      (i_clk),
        .i_days     (r_c_days),
        .i_tod      (r_c_tod),
        .i_in_range (r_c_ok),
        .o_clock    (w_clock)
    );

    // Delay the shorter time-of-day path to line up with the date
    etc_pkg::t_clock r_pad [etc_pkg::PAD_DEPTH];

    always_ff @(posedge i_clk) begin
        r_pad[0] <= w_clock;
        for (int i = 1; i < etc_pkg::PAD_DEPTH; i++) begin
            r_pad[i] <= r_pad[i-1];
        end
    end

    assign o_strobe   = w_date_vld;
    assign o_year     = w_date.year;
    assign o_month    = w_date.month;
    assign o_day      = w_date.day;
    assign o_hour     = r_pad[etc_pkg::PAD_DEPTH-1].hour;
    assign o_minute   = r_pad[etc_pkg::PAD_DEPTH-1].minute;
    assign o_second   = r_pad[etc_pkg::PAD_DEPTH-1].second;
    assign o_weekday  = r_pad[etc_pkg::PAD_DEPTH-1].weekday;
    assign o_in_range = r_pad[etc_pkg::PAD_DEPTH-1].in_range;

endmodule

@@ hw/rtl/etc_clock.sv @@
// Time of day, weekday and range flag pipeline.
module etc_clock (
    input  logic                         i_clk,
    input  logic [etc_pkg::DAYS_W-1:0]   i_days,
    input  logic [etc_pkg::TOD_W-1:0]    i_tod,
    input  logic                         i_in_range,
    output etc_pkg::t_clock              o_clock
);

    localparam int HP_W = etc_pkg::TOD_W + etc_pkg::MINUTE_W;
    localparam int WP_W = etc_pkg::WD_W + etc_pkg::WQ_W;
    localparam int MP_W = etc_pkg::MREM_W + etc_pkg::MINUTE_W;

    // stage 1: quotient estimates
    logic [HP_W-1:0]                n1_hprod;
    logic [etc_pkg::WD_W-1:0]       n1_w;
    logic [WP_W-1:0]                n1_wprod;
    logic [etc_pkg::HOUR_W-1:0]     r1_hq;
    logic [etc_pkg::TOD_W-1:0]      r1_tod;
    logic [etc_pkg::WD_W-1:0]       r1_w;
    logic [etc_pkg::WQ_W-1:0]       r1_wq;
    logic                           r1_ok;

    assign n1_hprod = HP_W'(i_tod) * HP_W'(etc_pkg::HOUR_RECIP);
    assign n1_w     = etc_pkg::WD_W'(i_days) + etc_pkg::WD_W'(etc_pkg::WEEK_OFFSET);
    assign n1_wprod = WP_W'(n1_w) * WP_W'(etc_pkg::WEEK_RECIP);

    always_ff @(posedge i_clk) begin
        r1_hq  <= n1_hprod[etc_pkg::TOD_W +: etc_pkg::HOUR_W];
        r1_tod <= i_tod;
        r1_w   <= n1_w;
        r1_wq  <= n1_wprod[etc_pkg::WD_W +: etc_pkg::WQ_W];
        r1_ok  <= i_in_range;
    end

    // stage 2: hour and weekday corrections
    logic [etc_pkg::TOD_W-1:0]      n2_hrem;
    logic                           n2_hfix;
    logic [etc_pkg::TOD_W-1:0]      n2_mrem;
    logic [etc_pkg::WD_W-1:0]       n2_wrem;
    logic [3:0]                     n2_w4;
    logic [3:0]                     n2_wday;
    logic [etc_pkg::HOUR_W-1:0]     r2_hour;
    logic [etc_pkg::MREM_W-1:0]     r2_mrem;
    logic [etc_pkg::WDAY_W-1:0]     r2_wday;
    logic                           r2_ok;

    assign n2_hrem = r1_tod - etc_pkg::TOD_W'(r1_hq) * etc_pkg::TOD_W'(etc_pkg::SECS_PER_HOUR);
    assign n2_hfix = n2_hrem >= etc_pkg::TOD_W'(etc_pkg::SECS_PER_HOUR);
    assign n2_mrem = n2_hfix ? n2_hrem - etc_pkg::TOD_W'(etc_pkg::SECS_PER_HOUR) : n2_hrem;
    assign n2_wrem = r1_w - etc_pkg::WD_W'(r1_wq) * etc_pkg::WD_W'(etc_pkg::WEEK_DAYS);
    assign n2_w4   = n2_wrem[3:0];
    assign n2_wday = (n2_w4 >= 4'(etc_pkg::WEEK_DAYS)) ? n2_w4 - 4'(etc_pkg::WEEK_DAYS) : n2_w4;

    always_ff @(posedge i_clk) begin
        r2_hour <= r1_hq + etc_pkg::HOUR_W'(n2_hfix);
        r2_mrem <= n2_mrem[etc_pkg::MREM_W-1:0];
        r2_wday <= n2_wday[etc_pkg::WDAY_W-1:0];
        r2_ok   <= r1_ok;
    end

    // stage 3: minute estimate
    logic [MP_W-1:0]                n3_mprod;
    logic [etc_pkg::MINUTE_W-1:0]   r3_mq;
    logic [etc_pkg::MREM_W-1:0]     r3_mrem;
    logic [etc_pkg::HOUR_W-1:0]     r3_hour;
    logic [etc_pkg::WDAY_W-1:0]     r3_wday;
    logic                           r3_ok;

    assign n3_mprod = MP_W'(r2_mrem) * MP_W'(etc_pkg::MIN_RECIP);

    always_ff @(posedge i_clk) begin
        r3_mq   <= n3_mprod[etc_pkg::MREM_W +: etc_pkg::MINUTE_W];
        r3_mrem <= r2_mrem;
        r3_hour <= r2_hour;
        r3_wday <= r2_wday;
        r3_ok   <= r2_ok;
    end

    // stage 4: minute correction and seconds
    logic [etc_pkg::MREM_W-1:0]     n4_srem_full;
    logic [6:0]                     n4_srem;
    logic                           n4_sfix;
    logic [6:0]                     n4_sec;
    etc_pkg::t_clock                r4_clock;

    assign n4_srem_full = r3_mrem
                        - etc_pkg::MREM_W'(r3_mq) * etc_pkg::MREM_W'(etc_pkg::SECS_PER_MIN);
    assign n4_srem = n4_srem_full[6:0];
    assign n4_sfix = n4_srem >= 7'(etc_pkg::SECS_PER_MIN);
    assign n4_sec  = n4_sfix ? n4_srem - 7'(etc_pkg::SECS_PER_MIN) : n4_srem;

    always_ff @(posedge i_clk) begin
        r4_clock.hour     <= r3_hour;
        r4_clock.minute   <= r3_mq + etc_pkg::MINUTE_W'(n4_sfix);
        r4_clock.second   <= n4_sec[etc_pkg::SECOND_W-1:0];
        r4_clock.weekday  <= r3_wday;
        r4_clock.in_range <= r3_ok;
    end

    assign o_clock = r4_clock;

endmodule

@@ hw/rtl/etc_date.sv @@
// Civil date from day count: era / day-of-era method as a nine-stage pipeline.
module etc_date (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [etc_pkg::DAYS_W-1:0]  i_days,
    output logic                        o_vld,
    output etc_pkg::t_date              o_date
);

    localparam int DW  = etc_pkg::DOE_W;
    localparam int P2W = DW + etc_pkg::Q1460_W;
    localparam int P4W = DW + etc_pkg::YOE_W;
    localparam int P7W = etc_pkg::N_W + etc_pkg::MP_W;

    logic [etc_pkg::DATE_LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[etc_pkg::DATE_LAT-2:0], i_vld};
        end
    end

    assign o_vld = r_vld[etc_pkg::DATE_LAT-1];

    // s1: era and day of era
    logic          n1_hi;
    logic [DW-1:0] n1_doe;
    logic          r1_hi;
    logic [DW-1:0] r1_doe;

    assign n1_hi  = i_days >= etc_pkg::DAYS_W'(etc_pkg::ERA_SPLIT);
    assign n1_doe = n1_hi ? DW'(i_days) - DW'(etc_pkg::ERA_SPLIT)
                          : DW'(i_days) + DW'(etc_pkg::DOE_OFF_LO);

    always_ff @(posedge i_clk) begin
        r1_hi  <= n1_hi;
        r1_doe <= n1_doe;
    end

    // s2: leap-cycle estimate, century count, last day of era
    logic [P2W-1:0]                  n2_prod;
    logic [2:0]                      n2_cent;
    logic                            r2_hi;
    logic [DW-1:0]                   r2_doe;
    logic [etc_pkg::Q1460_W-1:0]     r2_q;
    logic [2:0]                      r2_cent;
    logic                            r2_last;

    assign n2_prod = P2W'(r1_doe) * P2W'(etc_pkg::LEAP_RECIP);
    assign n2_cent = 3'(r1_doe >= DW'(etc_pkg::CENT_DAYS))
                   + 3'(r1_doe >= DW'(2 * etc_pkg::CENT_DAYS))
                   + 3'(r1_doe >= DW'(3 * etc_pkg::CENT_DAYS))
                   + 3'(r1_doe >= DW'(4 * etc_pkg::CENT_DAYS));

    always_ff @(posedge i_clk) begin
        r2_hi   <= r1_hi;
        r2_doe  <= r1_doe;
        r2_q    <= n2_prod[DW +: etc_pkg::Q1460_W];
        r2_cent <= n2_cent;
        r2_last <= r1_doe == DW'(etc_pkg::ERA_LAST_DAY);
    end

    // s3: correct leap count, form the year numerator
    logic [DW-1:0] n3_rem;
    logic [DW-1:0] n3_q;
    logic          r3_hi;
    logic [DW-1:0] r3_doe;
    logic [DW-1:0] r3_t;

    assign n3_rem = r2_doe - DW'(r2_q) * DW'(etc_pkg::LEAP_DAYS);
    assign n3_q   = DW'(r2_q) + DW'(n3_rem >= DW'(etc_pkg::LEAP_DAYS));

    always_ff @(posedge i_clk) begin
        r3_hi  <= r2_hi;
        r3_doe <= r2_doe;
        r3_t   <= r2_doe - n3_q + DW'(r2_cent) - DW'(r2_last);
    end

    // s4: year-of-era estimate
    logic [P4W-1:0]                n4_prod;
    logic                          r4_hi;
    logic [DW-1:0]                 r4_doe;
    logic [DW-1:0]                 r4_t;
    logic [etc_pkg::YOE_W-1:0]     r4_q;

    assign n4_prod = P4W'(r3_t) * P4W'(etc_pkg::YEAR_RECIP);

    always_ff @(posedge i_clk) begin
        r4_hi  <= r3_hi;
        r4_doe <= r3_doe;
        r4_t   <= r3_t;
        r4_q   <= n4_prod[DW +: etc_pkg::YOE_W];
    end

    // s5: correct year of era
    logic [DW-1:0]                 n5_rem;
    logic                          r5_hi;
    logic [DW-1:0]                 r5_doe;
    logic [etc_pkg::YOE_W-1:0]     r5_yoe;

    assign n5_rem = r4_t - DW'(r4_q) * DW'(etc_pkg::YEAR_DAYS);

    always_ff @(posedge i_clk) begin
        r5_hi  <= r4_hi;
        r5_doe <= r4_doe;
        r5_yoe <= r4_q + etc_pkg::YOE_W'(n5_rem >= DW'(etc_pkg::YEAR_DAYS));
    end

    // s6: day of year and March-based year
    logic [1:0]                    n6_c100;
    logic [DW-1:0]                 n6_sub;
    logic [DW-1:0]                 n6_doy;
    logic [etc_pkg::DOY_W-1:0]     r6_doy;
    logic [etc_pkg::YEAR_W-1:0]    r6_yr;

    assign n6_c100 = 2'(r5_yoe >= etc_pkg::YOE_W'(100))
                   + 2'(r5_yoe >= etc_pkg::YOE_W'(200))
                   + 2'(r5_yoe >= etc_pkg::YOE_W'(300));
    assign n6_sub  = DW'(r5_yoe) * DW'(etc_pkg::YEAR_DAYS) + DW'(r5_yoe >> 2) - DW'(n6_c100);
    assign n6_doy  = r5_doe - n6_sub;

    always_ff @(posedge i_clk) begin
        r6_doy <= n6_doy[etc_pkg::DOY_W-1:0];
        r6_yr  <= etc_pkg::YEAR_W'(r5_yoe)
                + (r5_hi ? etc_pkg::YEAR_W'(etc_pkg::YEAR_BASE_HI)
                         : etc_pkg::YEAR_W'(etc_pkg::YEAR_BASE_LO));
    end

    // s7: month estimate, (5 * doy + 2) * recip folded into one product
    logic [P7W-1:0]                n7_prod;
    logic [etc_pkg::MP_W-1:0]      r7_q;
    logic [etc_pkg::DOY_W-1:0]     r7_doy;
    logic [etc_pkg::YEAR_W-1:0]    r7_yr;

    assign n7_prod = P7W'(r6_doy) * P7W'(5 * etc_pkg::MP_RECIP) + P7W'(2 * etc_pkg::MP_RECIP);

    always_ff @(posedge i_clk) begin
        r7_q   <= n7_prod[etc_pkg::N_W +: etc_pkg::MP_W];
        r7_doy <= r6_doy;
        r7_yr  <= r6_yr;
    end

    // s8: correct month
    logic [etc_pkg::N_W-1:0]       n8_n;
    logic [etc_pkg::N_W-1:0]       n8_rem;
    logic [etc_pkg::MP_W-1:0]      r8_mp;
    logic [etc_pkg::DOY_W-1:0]     r8_doy;
    logic [etc_pkg::YEAR_W-1:0]    r8_yr;

    assign n8_n   = etc_pkg::N_W'(r7_doy) * etc_pkg::N_W'(5) + etc_pkg::N_W'(2);
    assign n8_rem = n8_n - etc_pkg::N_W'(r7_q) * etc_pkg::N_W'(etc_pkg::MONTH_SPAN);

    always_ff @(posedge i_clk) begin
        r8_mp  <= r7_q + etc_pkg::MP_W'(n8_rem >= etc_pkg::N_W'(etc_pkg::MONTH_SPAN));
        r8_doy <= r7_doy;
        r8_yr  <= r7_yr;
    end

    // s9: calendar month, day, January/February roll into next year
    logic [etc_pkg::DOY_W-1:0]     n9_day;
    logic [etc_pkg::MONTH_W-1:0]   n9_mo;
    etc_pkg::t_date                r9_date;

    assign n9_day = r8_doy - etc_pkg::month_offset(r8_mp) + etc_pkg::DOY_W'(1);
    assign n9_mo  = (r8_mp < etc_pkg::MP_W'(10)) ? r8_mp + etc_pkg::MONTH_W'(3)
                                                 : r8_mp - etc_pkg::MONTH_W'(9);

    always_ff @(posedge i_clk) begin
        r9_date.day   <= n9_day[etc_pkg::DAY_W-1:0];
        r9_date.month <= n9_mo;
        r9_date.year  <= r8_yr + etc_pkg::YEAR_W'(n9_mo <= etc_pkg::MONTH_W'(2));
    end

    assign o_date = r9_date;

endmodule

@@ hw/rtl/etc_checker.sv @@
// Port-level checker for epoch_to_calendar, attached by bind.
module etc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [etc_pkg::EPOCH_W-1:0]     i_epoch_seconds,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [etc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [etc_pkg::EPOCH_W-1:0]     i_cfg_data,
    input  logic                            o_strobe,
    input  logic [etc_pkg::YEAR_W-1:0]      o_year,
    input  logic [etc_pkg::MONTH_W-1:0]     o_month,
    input  logic [etc_pkg::DAY_W-1:0]       o_day,
    input  logic [etc_pkg::HOUR_W-1:0]      o_hour,
    input  logic [etc_pkg::MINUTE_W-1:0]    o_minute,
    input  logic [etc_pkg::SECOND_W-1:0]    o_second,
    input  logic [etc_pkg::WDAY_W-1:0]      o_weekday,
    input  logic                            o_in_range
);

    localparam int RUN_W = $clog2(etc_pkg::TOTAL_LAT + 1);

    // Shadow bounds and a count of reset-free cycles
    logic [etc_pkg::EPOCH_W-1:0] r_floor;
    logic [etc_pkg::EPOCH_W-1:0] r_max;
    logic [RUN_W-1:0]            r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= etc_pkg::RESET_FLOOR;
            r_max   <= etc_pkg::RESET_MAX;
            r_run   <= '0;
        end else begin
            if (r_run != RUN_W'(etc_pkg::TOTAL_LAT)) begin
                r_run <= r_run + RUN_W'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    etc_pkg::CFG_SYNC_FLOOR: r_floor <= i_cfg_data;
                    etc_pkg::CFG_MAX_EPOCH:  r_max   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // One result per request, checked once the run counter has saturated
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run == RUN_W'(etc_pkg::TOTAL_LAT))
            |-> (o_strobe == $past(start && !busy, etc_pkg::TOTAL_LAT)))
        else $error("result strobe does not match request issued TOTAL_LAT cycles earlier");

    // Range flag follows the bounds in force when the request was taken
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_run == RUN_W'(etc_pkg::TOTAL_LAT))
            |-> (o_in_range ==
                 (($past(i_epoch_seconds, etc_pkg::TOTAL_LAT) >= $past(r_floor, etc_pkg::TOTAL_LAT))
               && ($past(i_epoch_seconds, etc_pkg::TOTAL_LAT) <= $past(r_max, etc_pkg::TOTAL_LAT)))))
        else $error("in_range flag disagrees with bounds");

    // Result fields stay within calendar ranges
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_month >= etc_pkg::MONTH_W'(1) && o_month <= etc_pkg::MONTH_W'(12)
                   && o_day >= etc_pkg::DAY_W'(1) && o_hour <= etc_pkg::HOUR_W'(23)
                   && o_minute <= etc_pkg::MINUTE_W'(59) && o_second <= etc_pkg::SECOND_W'(59)
                   && o_weekday <= etc_pkg::WDAY_W'(6)
                   && o_year >= etc_pkg::YEAR_W'(1970) && o_year <= etc_pkg::YEAR_W'(2106)))
        else $error("result field out of calendar range");

    // Reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe seen right after reset");

endmodule

bind epoch_to_calendar etc_checker u_etc_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the epoch to calendar converter.
`timescale 1ns / 1ps

module tb_top;

    localparam int EW = etc_pkg::EPOCH_W;
    localparam int IW = etc_pkg::CFG_IDX_W;

    // Calendar arithmetic constants
    localparam logic [31:0] SEC_DAY     = 32'd86400;
    localparam logic [31:0] SEC_HOUR    = 32'd3600;
    localparam logic [31:0] SEC_MIN     = 32'd60;
    localparam logic [31:0] MARCH_SHIFT = 32'd719468;   // day 0 becomes 0000-03-01
    localparam logic [31:0] ERA_DAYS    = 32'd146097;

    // Register indexes outside the map, writes there must be dropped
    localparam logic [IW-1:0] CFG_IDX_NEXT = IW'(etc_pkg::CFG_MAX_EPOCH) + 1'b1;
    localparam logic [IW-1:0] CFG_IDX_TOP  = '1;

    // Drain wait once the expectation queue is empty
    localparam int SETTLE_CYCLES = etc_pkg::TOTAL_LAT + 4;

    // Calendar dates around leap days, century years, era and 32-bit limits
    localparam logic [31:0] LANDMARKS [20] = '{
        32'd0,          32'd1,          32'd86399,      32'd86400,
        32'd68169600,   32'd68255999,   32'd946684799,  32'd946684800,
        32'd951782400,  32'd951868799,  32'd951868800,  32'd1599999999,
        32'd1600000000, 32'd2147483647, 32'd2147483648, 32'd4102444799,
        32'd4102444800, 32'd4107542399, 32'd4107542400, 32'hFFFF_FFFF
    };

    typedef struct packed {
        logic [etc_pkg::YEAR_W-1:0]   year;
        logic [etc_pkg::MONTH_W-1:0]  month;
        logic [etc_pkg::DAY_W-1:0]    day;
        logic [etc_pkg::HOUR_W-1:0]   hour;
        logic [etc_pkg::MINUTE_W-1:0] minute;
        logic [etc_pkg::SECOND_W-1:0] second;
        logic [etc_pkg::WDAY_W-1:0]   weekday;
        logic                         in_range;
    } t_cal;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [EW-1:0] i_epoch_seconds = '0;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [IW-1:0] i_cfg_index = '0;
    logic [EW-1:0] i_cfg_data = '0;

    logic                         o_strobe;
    logic [etc_pkg::YEAR_W-1:0]   o_year;
    logic [etc_pkg::MONTH_W-1:0]  o_month;
    logic [etc_pkg::DAY_W-1:0]    o_day;
    logic [etc_pkg::HOUR_W-1:0]   o_hour;
    logic [etc_pkg::MINUTE_W-1:0] o_minute;
    logic [etc_pkg::SECOND_W-1:0] o_second;
    logic [etc_pkg::WDAY_W-1:0]   o_weekday;
    logic                         o_in_range;

    // Predictor's copy of the two bound registers
    logic [31:0] bound_floor = etc_pkg::RESET_FLOOR;
    logic [31:0] bound_max   = etc_pkg::RESET_MAX;

    logic [31:0] epoch_backlog [$];   // requests not yet presented
    t_cal        calendar_due [$];    // dates owed by the pipeline, oldest first
    logic        req_taken = 1'b0;    // request accepted at the last rising edge
    int          gap_left = 0;
    bit          no_gaps = 1'b0;
    int          mismatches = 0;

    epoch_to_calendar i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_epoch_seconds(i_epoch_seconds),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day          (o_day),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second),
        .o_weekday      (o_weekday),
        .o_in_range     (o_in_range)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Civil-from-days on March-based years, plus time of day, weekday and bounds
    function automatic t_cal civil_from_epoch(input logic [31:0] ep,
                                              input logic [31:0] lo,
                                              input logic [31:0] hi);
        logic [31:0] days, z, era, doe, yoe, yr, doy, mp, dom, mo, tod, wd;
        t_cal        r;
        days = ep / SEC_DAY;
        z    = days + MARCH_SHIFT;
        era  = z / ERA_DAYS;
        doe  = z - era * ERA_DAYS;
        yoe  = (doe - doe / 32'd1460 + doe / 32'd36524 - doe / 32'd146096) / 32'd365;
        yr   = yoe + era * 32'd400;
        doy  = doe - (32'd365 * yoe + yoe / 32'd4 - yoe / 32'd100);
        mp   = (32'd5 * doy + 32'd2) / 32'd153;
        dom  = doy - (32'd153 * mp + 32'd2) / 32'd5 + 32'd1;
        mo   = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
        if (mo <= 32'd2) begin
            yr = yr + 32'd1;    // Jan and Feb belong to the next civil year
        end
        tod = ep % SEC_DAY;
        wd  = (days + 32'd4) % 32'd7;   // day 0 was a Thursday
        r.year     = yr[etc_pkg::YEAR_W-1:0];
        r.month    = mo[etc_pkg::MONTH_W-1:0];
        r.day      = dom[etc_pkg::DAY_W-1:0];
        r.hour     = 5'((tod / SEC_HOUR) & 32'h1F);
        r.minute   = 6'(((tod % SEC_HOUR) / SEC_MIN) & 32'h3F);
        r.second   = 6'((tod % SEC_MIN) & 32'h3F);
        r.weekday  = wd[etc_pkg::WDAY_W-1:0];
        r.in_range = (ep >= lo) && (ep <= hi);   // empty when lo > hi
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Request driver: holds a request until taken, then draws the gap after it
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (gap_left != 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (epoch_backlog.size() != 0) begin
                i_epoch_seconds <= epoch_backlog.pop_front();
                start           <= 1'b1;
                gap_left        <= no_gaps ? 0 : $urandom_range(0, 11);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Acceptance and result monitor
    always @(posedge i_clk) begin
        t_cal want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= start && !busy;
            if (start && !busy) begin
                calendar_due.push_back(civil_from_epoch(i_epoch_seconds, bound_floor,
                                                        bound_max));
            end
            if (o_strobe) begin
                if (calendar_due.size() == 0) begin
                    flag_mismatch("result with no request outstanding", 32'(o_year), 32'd0);
                end else begin
                    want = calendar_due.pop_front();
                    if (o_year !== want.year) begin
                        flag_mismatch("year", 32'(o_year), 32'(want.year));
                    end
                    if (o_month !== want.month) begin
                        flag_mismatch("month", 32'(o_month), 32'(want.month));
                    end
                    if (o_day !== want.day) begin
                        flag_mismatch("day", 32'(o_day), 32'(want.day));
                    end
                    if (o_hour !== want.hour) begin
                        flag_mismatch("hour", 32'(o_hour), 32'(want.hour));
                    end
                    if (o_minute !== want.minute) begin
                        flag_mismatch("minute", 32'(o_minute), 32'(want.minute));
                    end
                    if (o_second !== want.second) begin
                        flag_mismatch("second", 32'(o_second), 32'(want.second));
                    end
                    if (o_weekday !== want.weekday) begin
                        flag_mismatch("weekday", 32'(o_weekday), 32'(want.weekday));
                    end
                    if (o_in_range !== want.in_range) begin
                        flag_mismatch("in_range", 32'(o_in_range), 32'(want.in_range));
                    end
                end
            end
        end
    end

    // Config write; the predictor's bounds follow at the handshake edge
    task automatic write_bound(input logic [IW-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            etc_pkg::CFG_SYNC_FLOOR: bound_floor = value;
            etc_pkg::CFG_MAX_EPOCH:  bound_max   = value;
            default: ;   // unmapped index, dropped
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for every queued request to be taken and every date to come back
    task automatic drain_pipeline();
        do @(negedge i_clk);
        while (epoch_backlog.size() != 0 || start || calendar_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mix of raw words, values hugging the bounds, midnight edges and both ends
    function automatic logic [31:0] pick_epoch();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0, 1:    v = $urandom;
            2:       v = bound_floor + 32'($urandom_range(0, 8)) - 32'd4;
            3:       v = bound_max + 32'($urandom_range(0, 8)) - 32'd4;
            4:       v = 32'($urandom_range(0, 49710)) * SEC_DAY
                         + 32'($urandom_range(0, 4)) - 32'd2;
            5:       v = 32'($urandom_range(0, 400000));
            6:       v = 32'hFFFF_FFFF - 32'($urandom_range(0, 400000));
            default: v = 32'($urandom_range(0, 49710)) * SEC_DAY
                         + 32'($urandom_range(0, 86399));
        endcase
        return v;
    endfunction

    task automatic queue_random(input int count);
        repeat (count) epoch_backlog.push_back(pick_epoch());
    endtask

    initial begin
        logic [31:0] pivot;
        logic [31:0] lo_pick;
        logic [31:0] hi_pick;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset bounds: calendar landmarks, then random traffic
        foreach (LANDMARKS[k]) epoch_backlog.push_back(LANDMARKS[k]);
        queue_random(250);
        drain_pipeline();

        // Everything in range, back-to-back requests
        write_bound(etc_pkg::CFG_SYNC_FLOOR, 32'd0);
        write_bound(etc_pkg::CFG_MAX_EPOCH, 32'hFFFF_FFFF);
        no_gaps = 1'b1;
        queue_random(250);
        drain_pipeline();
        no_gaps = 1'b0;

        // Single-point window
        pivot = $urandom;
        write_bound(etc_pkg::CFG_SYNC_FLOOR, pivot);
        write_bound(etc_pkg::CFG_MAX_EPOCH, pivot);
        epoch_backlog.push_back(pivot - 32'd1);
        epoch_backlog.push_back(pivot);
        epoch_backlog.push_back(pivot + 32'd1);
        queue_random(200);
        drain_pipeline();

        // Floor above maximum, plus writes to unmapped indexes that must not land
        write_bound(etc_pkg::CFG_SYNC_FLOOR, 32'd3000000000);
        write_bound(etc_pkg::CFG_MAX_EPOCH, 32'd1000000000);
        write_bound(CFG_IDX_NEXT, $urandom);
        write_bound(CFG_IDX_TOP, 32'd0);
        queue_random(200);
        drain_pipeline();

        // Window pinned at the top word
        write_bound(etc_pkg::CFG_SYNC_FLOOR, 32'hFFFF_FFFF);
        write_bound(etc_pkg::CFG_MAX_EPOCH, 32'hFFFF_FFFF);
        epoch_backlog.push_back(32'hFFFF_FFFE);
        epoch_backlog.push_back(32'hFFFF_FFFF);
        queue_random(200);
        drain_pipeline();

        // Window pinned at zero
        write_bound(etc_pkg::CFG_SYNC_FLOOR, 32'd0);
        write_bound(etc_pkg::CFG_MAX_EPOCH, 32'd0);
        epoch_backlog.push_back(32'd0);
        epoch_backlog.push_back(32'd1);
        queue_random(200);
        drain_pipeline();

        // Random windows, ordered or not, random gap mode
        repeat (3) begin
            lo_pick = $urandom;
            hi_pick = $urandom;
            if ($urandom_range(0, 3) != 0 && lo_pick > hi_pick) begin
                pivot   = lo_pick;
                lo_pick = hi_pick;
                hi_pick = pivot;
            end
            write_bound(etc_pkg::CFG_MAX_EPOCH, hi_pick);
            write_bound(etc_pkg::CFG_SYNC_FLOOR, lo_pick);
            no_gaps = ($urandom_range(0, 2) == 0);
            queue_random(150);
            drain_pipeline();
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ epoch_to_calendar.f @@
hw/rtl/etc_pkg.sv
hw/rtl/etc_clock.sv
hw/rtl/etc_date.sv
hw/rtl/epoch_to_calendar.sv
hw/rtl/etc_checker.sv
tb/tb_top.sv
